>>> design/assert_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

>>> design/itp_pkg.sv
// Shared types, constants and helpers for the infix-to-postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;

  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_OVERFLOW        = 2'd1,
    ST_UNMATCHED_CLOSE = 2'd2,
    ST_UNMATCHED_OPEN  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CLS_FLUSH,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_TAIL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             has;
    logic             done;
    status_t          status;
  } res_t;

  typedef struct packed {
    logic direct;
    logic push;
    logic finish;
    res_t res;
  } emit_req_t;

  typedef struct packed {
    logic room;
    logic slot_free;
  } emit_stat_t;

  function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    return p;
  endfunction

  function automatic cls_t classify(input logic [SYM_W-1:0] c, input logic eoe);
    cls_t k;
    if (eoe) k = CLS_FLUSH;
    else if (c == CH_OPEN) k = CLS_OPEN;
    else if (c == CH_CLOSE) k = CLS_CLOSE;
    else if (prec_of(c) != 2'd0) k = CLS_OP;
    else k = CLS_OTHER;
    return k;
  endfunction

endpackage

>>> design/itp_stack_ram.sv
// Single-port-write, registered-read RAM holding the operator stack.
`timescale 1ns / 1ps

module itp_stack_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/itp_emit.sv
// Result staging: one pending beat plus the output register, sets the last flag.
`timescale 1ns / 1ps

module itp_emit import itp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  emit_req_t        req,
  output emit_stat_t       stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_has_symbol,
  output logic             out_last,
  output logic             out_expression_done,
  output logic [1:0]       out_status
);

  logic out_valid_r;
  logic pend_valid_r;
  res_t out_res_r;
  logic out_last_r;
  res_t pend_res_r;
  logic slot_free;
  logic load_out;

  assign slot_free = !out_valid_r || !out_stall;
  assign load_out  = req.direct || ((req.push || req.finish) && pend_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= load_out || (out_valid_r && out_stall);
      pend_valid_r <= req.push || (pend_valid_r && !req.finish);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r  <= req.direct ? req.res : pend_res_r;
      out_last_r <= req.direct || req.finish;
    end
    if (req.push) begin
      pend_res_r <= req.res;
    end
  end

  assign stat.slot_free = slot_free;
  assign stat.room      = !pend_valid_r || slot_free;

  assign out_valid           = out_valid_r;
  assign out_symbol          = out_res_r.sym;
  assign out_has_symbol      = out_res_r.has;
  assign out_last            = out_last_r;
  assign out_expression_done = out_res_r.done;
  assign out_status          = out_res_r.status;

endmodule

>>> design/itp_ctrl.sv
// Sequencer: classifies beats, walks the stack RAM and requests results.
`timescale 1ns / 1ps

module itp_ctrl import itp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_end_of_expression,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [SYM_W-1:0]  ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [SYM_W-1:0]  ram_rdata,
  output emit_req_t         req,
  input  emit_stat_t        stat
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SYM_W-1:0] sym_r, sym_nxt;
  cls_t             cls_r, cls_nxt;
  logic             open_left_r, open_left_nxt;
  res_t             tail_r, tail_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic             empty;
  logic             full;
  logic             last_pop;
  cls_t             cls_in;
  logic             in_accept;
  logic [1:0]       top_prec;
  logic [1:0]       sym_prec;
  logic             top_is_open;
  logic             tp_gt;
  logic             tp_eq;
  logic             eval_emits;
  logic             hold;
  res_t             top_res;

  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign empty       = (cnt_r == '0);
  assign full        = (cnt_r == CNT_W'(STACK_DEPTH));
  assign last_pop    = (cnt_m1 == '0);
  assign cls_in      = classify(in_symbol, in_end_of_expression);
  assign in_stall    = !((state_r == S_IDLE) && stat.slot_free);
  assign in_accept   = in_valid && !in_stall;
  assign top_prec    = prec_of(ram_rdata);
  assign sym_prec    = prec_of(sym_r);
  assign top_is_open = (ram_rdata == CH_OPEN);
  assign tp_gt       = (top_prec > sym_prec);
  assign tp_eq       = (top_prec == sym_prec);
  assign top_res     = '{sym: ram_rdata, has: 1'b1, done: 1'b0, status: ST_OK};

  always_comb begin
    case (cls_r)
      CLS_FLUSH, CLS_CLOSE: eval_emits = !top_is_open;
      CLS_OP:               eval_emits = tp_gt || tp_eq;
      default:              eval_emits = 1'b0;
    endcase
  end

  assign hold = eval_emits && !stat.room;

  // RAM reads happen only in S_READ and writes never there, so no overlap.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (cls_in)
            CLS_FLUSH, CLS_CLOSE, CLS_OP: if (!empty) state_nxt = S_READ;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: state_nxt = S_EVAL;
      S_EVAL: begin
        if (!hold) begin
          case (cls_r)
            CLS_FLUSH: state_nxt = last_pop ? S_TAIL : S_READ;
            CLS_CLOSE: begin
              if (top_is_open) state_nxt = S_FINISH;
              else state_nxt = last_pop ? S_TAIL : S_READ;
            end
            CLS_OP: begin
              if (tp_gt) state_nxt = last_pop ? S_FINISH : S_READ;
              else if (tp_eq) state_nxt = S_FINISH;
              else state_nxt = full ? S_TAIL : S_FINISH;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_TAIL:   if (stat.room) state_nxt = S_FINISH;
      S_FINISH: if (stat.room) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    sym_nxt       = sym_r;
    cls_nxt       = cls_r;
    open_left_nxt = open_left_r;
    tail_nxt      = tail_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[ADDR_W-1:0];
    ram_wdata     = sym_r;
    ram_re        = (state_r == S_READ);
    ram_raddr     = cnt_m1[ADDR_W-1:0];
    req           = '0;
    req.res       = top_res;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sym_nxt       = in_symbol;
          cls_nxt       = cls_in;
          open_left_nxt = 1'b0;
          ram_wdata     = in_symbol;
          case (cls_in)
            CLS_FLUSH: begin
              if (empty) begin
                req.direct = 1'b1;
                req.res    = '{sym: '0, has: 1'b0, done: 1'b1, status: ST_OK};
              end
            end
            CLS_OPEN: begin
              if (full) begin
                req.direct = 1'b1;
                req.res    = '{sym: '0, has: 1'b0, done: 1'b0, status: ST_OVERFLOW};
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            CLS_CLOSE: begin
              if (empty) begin
                req.direct = 1'b1;
                req.res    = '{sym: '0, has: 1'b0, done: 1'b0, status: ST_UNMATCHED_CLOSE};
              end
            end
            CLS_OP: begin
              if (empty) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            default: begin
              req.direct = 1'b1;
              req.res    = '{sym: in_symbol, has: 1'b1, done: 1'b0, status: ST_OK};
            end
          endcase
        end
      end
      S_EVAL: begin
        if (!hold) begin
          case (cls_r)
            CLS_FLUSH: begin
              cnt_nxt = cnt_m1;
              if (top_is_open) open_left_nxt = 1'b1;
              else req.push = 1'b1;
              tail_nxt = '{sym: '0, has: 1'b0, done: 1'b1,
                           status: (open_left_r || top_is_open) ? ST_UNMATCHED_OPEN : ST_OK};
            end
            CLS_CLOSE: begin
              cnt_nxt  = cnt_m1;
              req.push = !top_is_open;
              tail_nxt = '{sym: '0, has: 1'b0, done: 1'b0, status: ST_UNMATCHED_CLOSE};
            end
            CLS_OP: begin
              tail_nxt = '{sym: '0, has: 1'b0, done: 1'b0, status: ST_OVERFLOW};
              if (tp_gt || tp_eq) begin
                req.push = 1'b1;
                if (tp_eq || last_pop) begin
                  // pop and push in place: top slot takes the new operator
                  ram_we    = 1'b1;
                  ram_waddr = cnt_m1[ADDR_W-1:0];
                end else begin
                  cnt_nxt = cnt_m1;
                end
              end else if (!full) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            default: cnt_nxt = cnt_r;
          endcase
        end
      end
      S_TAIL: begin
        if (stat.room) begin
          req.push = 1'b1;
          req.res  = tail_r;
        end
      end
      S_FINISH: req.finish = stat.room;
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    cls_r       <= cls_nxt;
    open_left_r <= open_left_nxt;
    tail_r      <= tail_nxt;
  end

endmodule

>>> design/infix_to_postfix_converter_top.sv
// Shunting-yard infix-to-postfix converter, top level.
// Input channel: one infix character per beat (in_symbol), or an end beat
//   (in_end_of_expression) that flushes the operator stack.
// Output channel: postfix characters and status beats; out_last marks the
//   final beat caused by an input beat, out_expression_done the end of a flush.
// Both channels: a beat moves when valid is high and stall is low.
// Sequencing: a beat answered without a stack read (pass-through,
//   '(' push or overflow, operator onto an empty stack, close or end on an
//   empty stack) is handled while idle; its result, if any, appears the next
//   cycle and the next beat can be taken then, so operands flow at one per
//   cycle while the receiver does not stall. Any other beat reads the stack
//   top first, each read through a RAM read state then an evaluate state; a
//   trailing status beat adds a tail state, then a finish state releases the
//   last result and lets the next beat in. The stack RAM's single read port
//   sets the pop rate. Input is taken only while the sequencer is idle and
//   the output register is free or being drained; a stalled receiver holds
//   the output register and back-pressures the input.
// Reset (rst_n, synchronous, active low) empties the stack and drops any
//   pending output; stack RAM contents are not cleared.
`timescale 1ns / 1ps

module infix_to_postfix_converter_top import itp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_end_of_expression,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_has_symbol,
  output logic             out_last,
  output logic             out_expression_done,
  output logic [1:0]       out_status
);

  `include "assert_macros.svh"

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [SYM_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [SYM_W-1:0]  ram_rdata;
  emit_req_t         req;
  emit_stat_t        stat;

  itp_stack_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(SYM_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  itp_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_symbol           (in_symbol),
    .in_end_of_expression(in_end_of_expression),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_re              (ram_re),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .req                 (req),
    .stat                (stat)
  );

  itp_emit u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .req                (req),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_symbol         (out_symbol),
    .out_has_symbol     (out_has_symbol),
    .out_last           (out_last),
    .out_expression_done(out_expression_done),
    .out_status         (out_status)
  );

  `ASSERT_NEVER(a_ram_rw_overlap, ram_we && ram_re, "stack RAM read and write in one cycle")
  `ASSERT_NEVER(a_push_no_room, (req.push || req.finish) && !stat.room, "result beat lost")
  `ASSERT_NEVER(a_direct_busy, req.direct && !stat.slot_free, "output register overwritten")
  `ASSERT_CLK(a_done_is_last, out_valid && out_expression_done |-> out_last, "done beat not last")

endmodule
